### rtl/ascii_number_parser_core_macros.svh
// assertion macros used by the parser core rtl
`ifndef ASCII_NUMBER_PARSER_CORE_MACROS_SVH
`define ASCII_NUMBER_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ANP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("anp assertion failed");
`define ANP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("anp assertion failed");
`else
`define ANP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ANP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/anp_pkg.sv
package anp_pkg;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [31:0] NARROW_MAX     = 32'd65535;
   localparam logic [3:0]  WIDE_LEN_LIMIT = 4'd11;
   localparam logic [3:0]  HEX_LEN_LIMIT  = 4'd7;
   localparam logic [3:0]  DEC_LEN_LIMIT  = 4'd6;
   localparam logic [3:0]  HEX_MIN_LEN    = 4'd2;
   localparam logic [3:0]  COUNT_MAX      = 4'd15;
   localparam logic [31:0] DEC_BASE       = 32'd10;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_X = 8'h58;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       wide_mode;
   } anp_req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        error;
   } anp_rsp_type;

   function automatic logic is_dec_char(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return is_dec_char(c) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
   endfunction

   // digit value of a hex character, 0 for anything else
   function automatic logic [3:0] hex_char_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (is_dec_char(c)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
         d = c - CH_UPPER_A + 8'd10;
      end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
         d = c - CH_LOWER_A + 8'd10;
      end
      return d[3:0];
   endfunction

endpackage

### rtl/anp_step.sv
module anp_step
   import anp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  anp_req_type item,
   output anp_rsp_type result
);

   logic [31:0] acc_ff, acc_in;
   logic [3:0]  count_ff, count_in;
   logic        first_zero_ff, first_zero_in;
   logic        hex_ff, hex_in;
   logic        bad_ff, bad_in;

   logic [7:0]  dec_digit;
   logic        is_prefix;
   logic        err;
   logic [31:0] val;

   assign dec_digit = item.ch - CH_ZERO;
   assign is_prefix = !item.wide_mode && (count_ff == 4'd1) && first_zero_ff && !hex_ff &&
                      ((item.ch == CH_LOWER_X) || (item.ch == CH_UPPER_X));

   // final check on the state built so far
   always_comb begin
      err = 1'b0;
      val = 32'd0;
      if (count_ff == 4'd0) begin
         err = 1'b0;
         val = 32'd0;
      end else if (item.wide_mode) begin
         err = bad_ff || hex_ff || (count_ff >= WIDE_LEN_LIMIT);
         val = acc_ff;
      end else if (hex_ff) begin
         err = bad_ff || (count_ff <= HEX_MIN_LEN) || (count_ff >= HEX_LEN_LIMIT);
         val = {16'd0, acc_ff[15:0]};
      end else begin
         err = bad_ff || (count_ff >= DEC_LEN_LIMIT);
         val = (acc_ff > NARROW_MAX) ? 32'd0 : acc_ff;
      end
      result.error = err;
      result.value = err ? 32'd0 : val;
   end

   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      first_zero_in = first_zero_ff;
      hex_in        = hex_ff;
      bad_in        = bad_ff;
      if (item.kind == KIND_END) begin
         acc_in        = 32'd0;
         count_in      = 4'd0;
         first_zero_in = 1'b0;
         hex_in        = 1'b0;
         bad_in        = 1'b0;
      end else begin
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + 4'd1;
         end
         if (!bad_ff) begin
            if (is_prefix) begin
               hex_in = 1'b1;
               acc_in = 32'd0;
            end else if (hex_ff) begin
               if (item.wide_mode || !is_hex_char(item.ch)) begin
                  bad_in = 1'b1;
               end else begin
                  acc_in = {acc_ff[27:0], hex_char_value(item.ch)};
               end
            end else if (!is_dec_char(item.ch)) begin
               bad_in = 1'b1;
            end else begin
               if (count_ff == 4'd0) begin
                  first_zero_in = (item.ch == CH_ZERO);
               end
               acc_in = acc_ff * DEC_BASE + {24'd0, dec_digit};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= 32'd0;
         count_ff      <= 4'd0;
         first_zero_ff <= 1'b0;
         hex_ff        <= 1'b0;
         bad_ff        <= 1'b0;
      end else if (advance) begin
         acc_ff        <= acc_in;
         count_ff      <= count_in;
         first_zero_ff <= first_zero_in;
         hex_ff        <= hex_in;
         bad_ff        <= bad_in;
      end
   end

endmodule

### rtl/ascii_number_parser_core.sv
// ascii number parser: takes one character transaction per cycle and, on an
// end-of-string transaction, returns one result transaction with the parsed
// value and an error flag. narrow mode reads 1-5 decimal digits (above 65535
// reads as 0) or 0x/0X with 1-4 hex digits; wide mode reads 1-10 decimal
// digits modulo 2^32. malformed or overlong strings give error with value 0,
// an empty string gives 0 without error. character transactions give no
// result. a new transaction is taken every cycle; an end transaction's result
// is built from the input register and then held in the result register,
// and the per-cycle limit is the multiply-by-ten-and-add of the
// accumulator update. only a stalled result held in the result register,
// with another end transaction waiting behind it, holds off the input side.
`include "ascii_number_parser_core_macros.svh"

module ascii_number_parser_core
   import anp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  anp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output anp_rsp_type rsp_data
);

   // input register
   logic        s1_valid_ff, s1_valid_in;
   anp_req_type s1_item_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   anp_rsp_type rsp_data_ff;

   logic        req_accept;
   logic        out_free;
   logic        s1_advance;
   logic        rsp_load;
   anp_rsp_type step_result;

   // result register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // characters only touch state; end transactions need room at the output
   assign s1_advance = s1_valid_ff && ((s1_item_ff.kind == KIND_CHAR) || out_free);
   assign rsp_load   = s1_valid_ff && (s1_item_ff.kind == KIND_END) && out_free;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= step_result;
      end
   end

   // parse state and end-of-string check
   anp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_advance),
      .item    (s1_item_ff),
      .result  (step_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an error result never carries a value
   `ANP_ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid_ff && rsp_data_ff.error,
                       rsp_data_ff.value == 32'd0)
   // character transactions never hold off the input side
   `ANP_ASSERT_IMPLIES(a_char_no_stall, clock, reset,
                       s1_valid_ff && (s1_item_ff.kind == KIND_CHAR), !req_stall)
   // a loaded result is offered on the next cycle
   `ANP_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_valid_ff)
   // stall toward the input only with a pending end transaction
   `ANP_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall,
                       s1_valid_ff && (s1_item_ff.kind == KIND_END) && rsp_valid_ff)

endmodule
